// File: hw/rtl/ngc_pkg.sv
// ============================================================================
// ngc_pkg: shared types and constants for the NGON connectivity block
// Field widths, register indexes, command, dimension and count codes.
// ============================================================================
`default_nettype none

package ngc_pkg;

    localparam int CFG_W          = 11;
    localparam int LAYOUT_W       = 2;
    localparam int IDX_W          = 32;
    localparam int ID_W           = 32;
    localparam int CNT_W          = 3;
    localparam int POS_W          = 35;
    localparam int DIM_W          = 2;
    localparam int DEF_MAX_POINTS = 1024;
    localparam int DIV_STEP       = 4;

    typedef enum logic [1:0] {
        CFG_POINTS_I = 2'd0,
        CFG_POINTS_J = 2'd1,
        CFG_POINTS_K = 2'd2,
        CFG_LAYOUT   = 2'd3
    } t_cfg_reg;

    localparam logic [LAYOUT_W-1:0] LAYOUT_TYPE3 = 2'd2;

    localparam logic CMD_FACE = 1'b0;
    localparam logic CMD_CELL = 1'b1;

    localparam logic [DIM_W-1:0] DIM_1D = 2'd1;
    localparam logic [DIM_W-1:0] DIM_2D = 2'd2;
    localparam logic [DIM_W-1:0] DIM_3D = 2'd3;

    localparam logic [CNT_W-1:0] CNT_ONE  = 3'd1;
    localparam logic [CNT_W-1:0] CNT_TWO  = 3'd2;
    localparam logic [CNT_W-1:0] CNT_FOUR = 3'd4;
    localparam logic [CNT_W-1:0] CNT_SIX  = 3'd6;
    localparam logic [CNT_W-1:0] CNT_NONE = 3'd0;

    // query kind: face/cell crossed with dimension and face family
    typedef enum logic [3:0] {
        K_F1  = 4'd0,
        K_F2A = 4'd1,
        K_F2B = 4'd2,
        K_F3I = 4'd3,
        K_F3J = 4'd4,
        K_F3K = 4'd5,
        K_C1  = 4'd6,
        K_C2  = 4'd7,
        K_C3  = 4'd8
    } t_kind;

endpackage

`default_nettype wire

// File: hw/rtl/ngc_req_if.sv
// ============================================================================
// ngc_req_if: request channel
// Carries one query word: command and linear item index.
// ============================================================================
`default_nettype none

interface ngc_req_if import ngc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             command;
    logic [IDX_W-1:0] item_index;

    modport source (output valid, output command, output item_index, input ready);
    modport sink   (input valid, input command, input item_index, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/ngc_res_if.sv
// ============================================================================
// ngc_res_if: result channel
// Carries one result word: count, six ids, start position, dimension, error.
// ============================================================================
`default_nettype none

interface ngc_res_if import ngc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] entry_count;
    logic [ID_W-1:0]  id_a;
    logic [ID_W-1:0]  id_b;
    logic [ID_W-1:0]  id_c;
    logic [ID_W-1:0]  id_d;
    logic [ID_W-1:0]  id_e;
    logic [ID_W-1:0]  id_f;
    logic [POS_W-1:0] start_position;
    logic [DIM_W-1:0] mesh_dimension;
    logic             range_error;

    modport source (output valid, output entry_count, output id_a, output id_b,
                    output id_c, output id_d, output id_e, output id_f,
                    output start_position, output mesh_dimension, output range_error,
                    input ready);
    modport sink   (input valid, input entry_count, input id_a, input id_b,
                    input id_c, input id_d, input id_e, input id_f,
                    input start_position, input mesh_dimension, input range_error,
                    output ready);
endinterface

`default_nettype wire

// File: hw/rtl/ngc_div.sv
// ============================================================================
// ngc_div: pipelined restoring divider
// Retires STEP_BITS quotient bits per stage; advances only when enabled.
// ============================================================================
`default_nettype none

module ngc_div #(
    parameter int NUM_W     = 32,
    parameter int DEN_W     = 11,
    parameter int STEP_BITS = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output      logic [NUM_W-1:0] o_quo
);

    localparam int DEPTH = NUM_W / STEP_BITS;

    logic [NUM_W-1:0] r_num [DEPTH];
    logic [DEN_W-1:0] r_rem [DEPTH];
    logic [DEN_W-1:0] r_den [DEPTH];
    logic [NUM_W-1:0] n_num [DEPTH];
    logic [DEN_W-1:0] n_rem [DEPTH];
    logic [DEN_W-1:0] n_den [DEPTH];

    // shift numerator bits into the remainder, quotient bits in at the bottom
    always_comb begin
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [DEN_W:0]   trial;
        for (int k = 0; k < DEPTH; k++) begin
            if (k == 0) begin
                num = i_num;
                rem = '0;
                den = i_den;
            end else begin
                num = r_num[k-1];
                rem = r_rem[k-1];
                den = r_den[k-1];
            end
            for (int b = 0; b < STEP_BITS; b++) begin
                trial = {rem, num[NUM_W-1]};
                num   = {num[NUM_W-2:0], 1'b0};
                if (trial >= {1'b0, den}) begin
                    rem    = DEN_W'(trial - {1'b0, den});
                    num[0] = 1'b1;
                end else begin
                    rem = trial[DEN_W-1:0];
                end
            end
            n_num[k] = num;
            n_rem[k] = rem;
            n_den[k] = den;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DEPTH; k++) begin
                r_num[k] <= n_num[k];
                r_rem[k] <= n_rem[k];
                r_den[k] <= n_den[k];
            end
        end
    end

    assign o_quo = r_num[DEPTH-1];

endmodule

`default_nettype wire

// File: hw/rtl/cartesian_ngon_connectivity.sv
// ============================================================================
// cartesian_ngon_connectivity: structured grid seen as an NGON mesh
// Face-to-nodes and cell-to-faces queries by linear index, fully pipelined.
// ============================================================================
// The block takes one query word per cycle while the output side does not
// stall and returns one result word per query, in order. The depth comes
// from two 8-stage pipelined dividers (4 quotient bits a stage) that split
// the index into its grid coordinates, plus a few stages for range checks,
// family selection and id assembly. Grid sizes and the layout mode feed a
// 4-stage chain of derived products (face and cell totals, family offsets);
// a query accepted right after a register write is held long enough in the
// front stages for that chain to settle. After reset the request side holds
// ready low while the chain fills. A stall at the output freezes the whole
// pipeline; nothing is dropped or repeated. Write the registers only while
// no query is in flight.
// ============================================================================
`default_nettype none

module cartesian_ngon_connectivity import ngc_pkg::*; #(
    parameter int MAX_POINTS_PER_AXIS = DEF_MAX_POINTS
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [1:0]          i_cfg_idx,
    input  wire logic [CFG_W-1:0]    i_cfg_data,
    ngc_req_if.sink                  i_req,
    ngc_res_if.source                o_res
);

    localparam int PW = $clog2(MAX_POINTS_PER_AXIS + 1);
    localparam int P2 = 2 * PW;
    localparam int P3 = 3 * PW;
    localparam int TW = P3 + 2;
    localparam int CW = (TW > IDX_W) ? TW : IDX_W;

    localparam int DIV_DEPTH = IDX_W / DIV_STEP;
    localparam int WARM      = 4;

    // pipeline stage map
    localparam int S_FLAG = WARM;
    localparam int S_SEL  = S_FLAG + 1;
    localparam int S_POS  = S_SEL + 1;
    localparam int S_Q1   = S_SEL + DIV_DEPTH + 1;
    localparam int S_Q2   = S_Q1 + DIV_DEPTH + 1;
    localparam int S_N1   = S_Q2 + 1;
    localparam int S_OUT  = S_N1 + 1;
    localparam int NS     = S_OUT + 1;

    typedef struct packed {
        logic                  cmd;
        logic [IDX_W-1:0]      idx;
        logic                  err;
        t_kind                 kind;
        logic [IDX_W-1:0]      x;
        logic [PW-1:0]         d1;
        logic [PW-1:0]         d2;
        logic [PW-1:0]         mulc;
        logic                  s1;
        logic [CNT_W-1:0]      count;
        logic [POS_W-1:0]      spos;
        logic [ID_W-1:0]       q1;
        logic [ID_W-1:0]       a;
        logic [ID_W-1:0]       b;
        logic [ID_W-1:0]       n1;
        logic [ID_W-1:0]       g;
        logic [ID_W-1:0]       h;
        logic [5:0][ID_W-1:0]  id;
    } t_item;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]    r_pts_i, r_pts_j, r_pts_k;
    logic [LAYOUT_W-1:0] r_layout;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pts_i  <= CFG_W'(2);
            r_pts_j  <= CFG_W'(2);
            r_pts_k  <= CFG_W'(2);
            r_layout <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_POINTS_I: r_pts_i  <= i_cfg_data;
                CFG_POINTS_J: r_pts_j  <= i_cfg_data;
                CFG_POINTS_K: r_pts_k  <= i_cfg_data;
                CFG_LAYOUT:   r_layout <= i_cfg_data[LAYOUT_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp a size into 1..MAX
    function automatic logic [PW-1:0] eff_size(input logic [CFG_W-1:0] v);
        if (v == '0) begin
            return PW'(1);
        end
        if (32'(v) > 32'(MAX_POINTS_PER_AXIS)) begin
            return PW'(MAX_POINTS_PER_AXIS);
        end
        return PW'(v);
    endfunction

    function automatic logic [PW-1:0] less_one(input logic [PW-1:0] v);
        return (v > PW'(1)) ? PW'(v - PW'(1)) : PW'(1);
    endfunction

    // ------------------------------------------------------------------
    // derived grid constants, level 1: clamped sizes, dimension, plane axes
    // ------------------------------------------------------------------
    logic [PW-1:0]    c_ni, c_nj, c_nk;
    logic [1:0]       c_ones;
    logic [DIM_W-1:0] c_dim;
    logic [PW-1:0]    c_na, c_nb;

    always_comb begin
        c_ni   = eff_size(r_pts_i);
        c_nj   = eff_size(r_pts_j);
        c_nk   = eff_size(r_pts_k);
        c_ones = 2'(c_ni == PW'(1)) + 2'(c_nj == PW'(1)) + 2'(c_nk == PW'(1));
        case (c_ones)
            2'd0:    c_dim = DIM_3D;
            2'd1:    c_dim = DIM_2D;
            default: c_dim = DIM_1D;
        endcase
        c_na = c_ni;
        c_nb = c_nj;
        if (c_dim == DIM_2D) begin
            if (c_nk == PW'(1)) begin
                c_na = c_ni;
                c_nb = c_nj;
            end else if (c_nj == PW'(1)) begin
                c_na = c_ni;
                c_nb = c_nk;
            end else begin
                c_na = c_nj;
                c_nb = c_nk;
            end
        end
    end

    logic [PW-1:0]    r_ni, r_nj, r_nk, r_ni1, r_nj1, r_nk1;
    logic [PW-1:0]    r_na, r_na1, r_nb, r_nb1;
    logic [DIM_W-1:0] r_dim;
    logic             r_shift;

    always_ff @(posedge i_clk) begin
        r_ni    <= c_ni;
        r_nj    <= c_nj;
        r_nk    <= c_nk;
        r_ni1   <= less_one(c_ni);
        r_nj1   <= less_one(c_nj);
        r_nk1   <= less_one(c_nk);
        r_na    <= c_na;
        r_na1   <= less_one(c_na);
        r_nb    <= c_nb;
        r_nb1   <= less_one(c_nb);
        r_dim   <= c_dim;
        r_shift <= (r_layout != LAYOUT_TYPE3);
    end

    // level 2: pairwise products
    logic [P2-1:0] r_ninj, r_pij1, r_pi1j, r_pi1j1, r_first, r_f2b;

    always_ff @(posedge i_clk) begin
        r_ninj  <= P2'(r_ni)  * P2'(r_nj);
        r_pij1  <= P2'(r_ni)  * P2'(r_nj1);
        r_pi1j  <= P2'(r_ni1) * P2'(r_nj);
        r_pi1j1 <= P2'(r_ni1) * P2'(r_nj1);
        r_first <= P2'(r_na)  * P2'(r_nb1);
        r_f2b   <= P2'(r_na1) * P2'(r_nb);
    end

    // level 3: family sizes and cell total
    logic [P3-1:0] r_nfi, r_nfj, r_nfk, r_ctot, r_tot1;
    logic [P2:0]   r_f2tot;

    always_ff @(posedge i_clk) begin
        r_nfi   <= P3'(r_pij1)  * P3'(r_nk1);
        r_nfj   <= P3'(r_pi1j)  * P3'(r_nk1);
        r_nfk   <= P3'(r_pi1j1) * P3'(r_nk);
        r_ctot  <= P3'(r_pi1j1) * P3'(r_nk1);
        r_tot1  <= P3'(r_ninj)  * P3'(r_nk);
        r_f2tot <= (P2+1)'(r_first) + (P2+1)'(r_f2b);
    end

    // level 4: face total and k-family offset
    logic [TW-1:0] r_ftot;
    logic [P3:0]   r_nfij;

    always_ff @(posedge i_clk) begin
        r_nfij <= (P3+1)'(r_nfi) + (P3+1)'(r_nfj);
        case (r_dim)
            DIM_1D:  r_ftot <= TW'(r_tot1);
            DIM_2D:  r_ftot <= TW'(r_f2tot);
            default: r_ftot <= TW'(r_nfi) + TW'(r_nfj) + TW'(r_nfk);
        endcase
    end

    // ------------------------------------------------------------------
    // reset warm-up: hold ready until the derived chain is filled
    // ------------------------------------------------------------------
    logic [2:0] r_warm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warm <= '0;
        end else if (r_warm != 3'(WARM)) begin
            r_warm <= r_warm + 3'd1;
        end
    end

    // ------------------------------------------------------------------
    // query pipeline
    // ------------------------------------------------------------------
    t_item          r_pipe [NS];
    t_item          n_pipe [NS];
    logic [NS-1:0]  r_vld;
    logic           w_en;
    logic [ID_W-1:0] w_q1, w_q2;

    // advance everything unless the output word is stuck
    assign w_en        = !r_vld[NS-1] || o_res.ready;
    assign i_req.ready = w_en && (r_warm == 3'(WARM));

    ngc_div #(
        .NUM_W     (IDX_W),
        .DEN_W     (PW),
        .STEP_BITS (DIV_STEP)
    ) u_div_a (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_pipe[S_SEL].x),
        .i_den (r_pipe[S_SEL].d1),
        .o_quo (w_q1)
    );

    ngc_div #(
        .NUM_W     (IDX_W),
        .DEN_W     (PW),
        .STEP_BITS (DIV_STEP)
    ) u_div_b (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_pipe[S_Q1].q1),
        .i_den (r_pipe[S_Q1].d2),
        .o_quo (w_q2)
    );

    always_comb begin
        t_item p;
        logic  lt_first, lt_nfi, lt_nfij, hi;

        n_pipe[0]     = '0;
        n_pipe[0].cmd = i_req.command;
        n_pipe[0].idx = i_req.item_index;
        for (int s = 1; s < NS; s++) begin
            n_pipe[s] = r_pipe[s-1];
        end

        // range check and family
        p        = r_pipe[S_FLAG-1];
        lt_first = CW'(p.idx) < CW'(r_first);
        lt_nfi   = CW'(p.idx) < CW'(r_nfi);
        lt_nfij  = CW'(p.idx) < CW'(r_nfij);
        if (p.cmd == CMD_CELL) begin
            hi = CW'(p.idx) >= CW'(r_ctot);
            case (r_dim)
                DIM_1D:  n_pipe[S_FLAG].kind = K_C1;
                DIM_2D:  n_pipe[S_FLAG].kind = K_C2;
                default: n_pipe[S_FLAG].kind = K_C3;
            endcase
        end else begin
            hi = CW'(p.idx) >= CW'(r_ftot);
            case (r_dim)
                DIM_1D:  n_pipe[S_FLAG].kind = K_F1;
                DIM_2D:  n_pipe[S_FLAG].kind = lt_first ? K_F2A : K_F2B;
                default: n_pipe[S_FLAG].kind = lt_nfi ? K_F3I :
                                               (lt_nfij ? K_F3J : K_F3K);
            endcase
        end
        n_pipe[S_FLAG].err = hi;

        // family-local index, divisors and recombination terms
        p = r_pipe[S_SEL-1];
        n_pipe[S_SEL].x    = p.idx;
        n_pipe[S_SEL].d1   = PW'(1);
        n_pipe[S_SEL].d2   = PW'(1);
        n_pipe[S_SEL].mulc = '0;
        n_pipe[S_SEL].s1   = 1'b0;
        case (p.kind)
            K_F1: begin
                n_pipe[S_SEL].count = CNT_ONE;
            end
            K_F2A: begin
                n_pipe[S_SEL].count = CNT_TWO;
            end
            K_F2B: begin
                n_pipe[S_SEL].count = CNT_TWO;
                n_pipe[S_SEL].x     = p.idx - IDX_W'(r_first);
                n_pipe[S_SEL].d1    = r_na1;
                n_pipe[S_SEL].s1    = 1'b1;
            end
            K_F3I: begin
                n_pipe[S_SEL].count = CNT_FOUR;
                n_pipe[S_SEL].d1    = r_ni;
                n_pipe[S_SEL].d2    = r_nj1;
                n_pipe[S_SEL].mulc  = r_ni;
            end
            K_F3J: begin
                n_pipe[S_SEL].count = CNT_FOUR;
                n_pipe[S_SEL].x     = p.idx - IDX_W'(r_nfi);
                n_pipe[S_SEL].d1    = r_ni1;
                n_pipe[S_SEL].d2    = r_nj;
                n_pipe[S_SEL].s1    = 1'b1;
            end
            K_F3K: begin
                n_pipe[S_SEL].count = CNT_FOUR;
                n_pipe[S_SEL].x     = p.idx - IDX_W'(r_nfij);
                n_pipe[S_SEL].d1    = r_ni1;
                n_pipe[S_SEL].d2    = r_nj1;
                n_pipe[S_SEL].mulc  = r_ni;
                n_pipe[S_SEL].s1    = 1'b1;
            end
            K_C1: begin
                n_pipe[S_SEL].count = CNT_TWO;
            end
            K_C2: begin
                n_pipe[S_SEL].count = CNT_FOUR;
                n_pipe[S_SEL].d1    = r_na1;
                n_pipe[S_SEL].s1    = 1'b1;
            end
            default: begin
                n_pipe[S_SEL].count = CNT_SIX;
                n_pipe[S_SEL].d1    = r_ni1;
                n_pipe[S_SEL].d2    = r_nj1;
                n_pipe[S_SEL].mulc  = r_ni1;
                n_pipe[S_SEL].s1    = 1'b1;
            end
        endcase

        // start position: (count + shift) * index
        p = r_pipe[S_POS-1];
        n_pipe[S_POS].spos = POS_W'(36'(p.count + CNT_W'(r_shift)) * 36'(p.idx));

        // first quotient
        n_pipe[S_Q1].q1 = w_q1;

        // second quotient folded into the node or face base
        p = r_pipe[S_Q2-1];
        n_pipe[S_Q2].a = p.x + (p.s1 ? p.q1 : '0);
        n_pipe[S_Q2].b = ID_W'(ID_W'(p.mulc) * w_q2);

        // bases
        p = r_pipe[S_N1-1];
        n_pipe[S_N1].n1 = p.a + ((p.kind == K_C3) ? '0 : p.b);
        n_pipe[S_N1].g  = (p.kind == K_C2) ? (ID_W'(r_first) + p.x)
                                           : (ID_W'(r_nfi) + p.x + p.b);
        n_pipe[S_N1].h  = ID_W'(r_nfij) + p.x;

        // 1-based ids
        p = r_pipe[S_OUT-1];
        n_pipe[S_OUT].id = '0;
        case (p.kind)
            K_F1: begin
                n_pipe[S_OUT].id[0] = p.n1 + 32'd1;
            end
            K_F2A: begin
                n_pipe[S_OUT].id[0] = p.n1 + 32'd1;
                n_pipe[S_OUT].id[1] = p.n1 + ID_W'(r_na) + 32'd1;
            end
            K_F2B, K_C1: begin
                n_pipe[S_OUT].id[0] = p.n1 + 32'd1;
                n_pipe[S_OUT].id[1] = p.n1 + 32'd2;
            end
            K_F3I: begin
                n_pipe[S_OUT].id[0] = p.n1 + 32'd1;
                n_pipe[S_OUT].id[1] = p.n1 + ID_W'(r_ni) + 32'd1;
                n_pipe[S_OUT].id[2] = p.n1 + ID_W'(r_ni) + ID_W'(r_ninj) + 32'd1;
                n_pipe[S_OUT].id[3] = p.n1 + ID_W'(r_ninj) + 32'd1;
            end
            K_F3J: begin
                n_pipe[S_OUT].id[0] = p.n1 + 32'd1;
                n_pipe[S_OUT].id[1] = p.n1 + 32'd2;
                n_pipe[S_OUT].id[2] = p.n1 + ID_W'(r_ninj) + 32'd2;
                n_pipe[S_OUT].id[3] = p.n1 + ID_W'(r_ninj) + 32'd1;
            end
            K_F3K: begin
                n_pipe[S_OUT].id[0] = p.n1 + 32'd1;
                n_pipe[S_OUT].id[1] = p.n1 + 32'd2;
                n_pipe[S_OUT].id[2] = p.n1 + ID_W'(r_ni) + 32'd2;
                n_pipe[S_OUT].id[3] = p.n1 + ID_W'(r_ni) + 32'd1;
            end
            K_C2: begin
                n_pipe[S_OUT].id[0] = p.n1 + 32'd1;
                n_pipe[S_OUT].id[1] = p.g + 32'd1;
                n_pipe[S_OUT].id[2] = p.n1 + 32'd2;
                n_pipe[S_OUT].id[3] = p.g + ID_W'(r_na1) + 32'd1;
            end
            default: begin
                n_pipe[S_OUT].id[0] = p.n1 + 32'd1;
                n_pipe[S_OUT].id[1] = p.n1 + 32'd2;
                n_pipe[S_OUT].id[2] = p.g + 32'd1;
                n_pipe[S_OUT].id[3] = p.g + ID_W'(r_ni1) + 32'd1;
                n_pipe[S_OUT].id[4] = p.h + 32'd1;
                n_pipe[S_OUT].id[5] = p.h + ID_W'(r_pi1j1) + 32'd1;
            end
        endcase
        // out of range: drop ids, count and position
        if (p.err) begin
            n_pipe[S_OUT].id    = '0;
            n_pipe[S_OUT].count = CNT_NONE;
            n_pipe[S_OUT].spos  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NS-2:0], i_req.valid && i_req.ready};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int s = 0; s < NS; s++) begin
                r_pipe[s] <= n_pipe[s];
            end
        end
    end

    // ------------------------------------------------------------------
    // result word
    // ------------------------------------------------------------------
    assign o_res.valid          = r_vld[NS-1];
    assign o_res.entry_count    = r_pipe[NS-1].count;
    assign o_res.id_a           = r_pipe[NS-1].id[0];
    assign o_res.id_b           = r_pipe[NS-1].id[1];
    assign o_res.id_c           = r_pipe[NS-1].id[2];
    assign o_res.id_d           = r_pipe[NS-1].id[3];
    assign o_res.id_e           = r_pipe[NS-1].id[4];
    assign o_res.id_f           = r_pipe[NS-1].id[5];
    assign o_res.start_position = r_pipe[NS-1].spos;
    assign o_res.mesh_dimension = r_dim;
    assign o_res.range_error    = r_pipe[NS-1].err;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_no_out_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("result valid right after reset");

    a_err_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.range_error) |->
            (o_res.entry_count == CNT_NONE && o_res.start_position == '0 &&
             o_res.id_a == '0 && o_res.id_f == '0))
        else $error("range error word carries data");

    a_count_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.range_error) |->
            (o_res.entry_count == CNT_ONE || o_res.entry_count == CNT_TWO ||
             o_res.entry_count == CNT_FOUR || o_res.entry_count == CNT_SIX))
        else $error("illegal entry count");

endmodule

`default_nettype wire
